// ===== hdl/gsaf_pkg.sv =====
// shared types, constants and helpers of the gnss speed and acceleration filter
package gsaf_pkg;

    localparam int SPEED_FRAC_BITS = 8;
    localparam int TIME_W          = 64;
    localparam int SPEED_W         = 16;
    localparam int HDOP_W          = 16;
    localparam int ALPHA_W         = 17;
    localparam int ACCEL_W         = 16;
    localparam int MAXA_W          = 15;
    localparam int MS_W            = 32;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int DT_W            = 21;
    localparam int NUM_W           = 36;
    localparam int CNT_W           = 6;
    localparam int LIM_W           = 42;
    localparam int CMP_W           = (TIME_W > LIM_W) ? TIME_W : LIM_W;
    localparam int MUL_W           = 18;
    localparam int PROD_W          = 2 * MUL_W;

    localparam logic MODE_READING = 1'b0;
    localparam logic MODE_QUERY   = 1'b1;

    localparam logic [DT_W-1:0]    DT_MIN     = 21'd20000;
    localparam logic [DT_W-1:0]    DT_MAX     = 21'd2000000;
    localparam logic [19:0]        US_PER_S   = 20'd1000000;
    localparam logic [9:0]         US_PER_MS  = 10'd1000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
    localparam logic [PROD_W-1:0]  ROUND_HALF = 36'd32768;
    localparam int                 EMA_SHIFT  = 16;

    localparam logic [SPEED_W-1:0] RST_DEADBAND   = SPEED_W'(1 << (SPEED_FRAC_BITS - 1));
    localparam logic [ALPHA_W-1:0] RST_ALPHA      = 17'd19661;
    localparam logic [HDOP_W-1:0]  RST_MAX_HDOP   = 16'd300;
    localparam logic [MAXA_W-1:0]  RST_MAX_ACCEL  = MAXA_W'(10 << SPEED_FRAC_BITS);
    localparam logic [SPEED_W-1:0] RST_MOVING     = SPEED_W'(2 << SPEED_FRAC_BITS);
    localparam logic [MS_W-1:0]    RST_MOVE_MEM   = 32'd5000;
    localparam logic [MS_W-1:0]    RST_HINT_AGE   = 32'd2000;

    typedef enum logic [2:0] {
        REG_SPEED_DEADBAND,
        REG_SPEED_ALPHA,
        REG_ACCEL_ALPHA,
        REG_MAX_HDOP,
        REG_MAX_ACCEL,
        REG_MOVING_SPEED,
        REG_MOVEMENT_MEMORY_MS,
        REG_MAX_HINT_AGE_MS
    } reg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_deadband;
        logic [ALPHA_W-1:0] speed_alpha;
        logic [ALPHA_W-1:0] accel_alpha;
        logic [HDOP_W-1:0]  max_hdop;
        logic [MAXA_W-1:0]  max_accel;
        logic [SPEED_W-1:0] moving_speed;
        logic [MS_W-1:0]    movement_memory_ms;
        logic [MS_W-1:0]    max_hint_age_ms;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SUPD,
        ST_AGATE,
        ST_NMUL,
        ST_DIV,
        ST_ACHK,
        ST_AMUL,
        ST_AUPD,
        ST_HIST,
        ST_AGE,
        ST_OUT,
        ST_HOLD
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SMUL,
        OP_SUPD,
        OP_AGATE,
        OP_NMUL,
        OP_DIV,
        OP_AMUL,
        OP_AUPD,
        OP_HIST,
        OP_AGE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_fix;
        logic take;
        logic div_last;
        logic q_ok;
    } dp_status_t;

    function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
        sat_alpha = (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

endpackage

// ===== hdl/gsaf_if.sv =====
// input and result channel interfaces
interface gsaf_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic                               has_fix;
    logic [gsaf_pkg::SPEED_W-1:0]       speed;
    logic [gsaf_pkg::HDOP_W-1:0]        hdop;
    logic [63:0]                        time_us;

    modport source (output valid, mode, has_fix, speed, hdop, time_us, input ready);
    modport sink   (input valid, mode, has_fix, speed, hdop, time_us, output ready);
endinterface

interface gsaf_out_if;
    logic                               valid;
    logic                               ready;
    logic [gsaf_pkg::SPEED_W-1:0]       filtered_speed;
    logic                               speed_valid;
    logic signed [gsaf_pkg::ACCEL_W-1:0] accel;
    logic                               accel_valid;
    logic                               moving;

    modport source (output valid, filtered_speed, speed_valid, accel, accel_valid, moving,
                    input ready);
    modport sink   (input valid, filtered_speed, speed_valid, accel, accel_valid, moving,
                    output ready);
endinterface

// ===== hdl/gnss_speed_accel_filter.sv =====
// top level of the gnss speed and acceleration filter
//
// One beat in, one beat out. A reading beat (mode 0) runs the speed deadband
// and ema, then the acceleration path; a query beat (mode 1) only evaluates
// the hints at the given time. Speeds are unsigned Q8.8 m/s, acceleration is
// signed Q8.8 m/s^2. The block handles one beat at a time and accepts no new
// beat until the result beat is taken. A reading that takes an acceleration
// sample also runs the 36-step restoring divider that forms speed difference
// times 1e6 over dt. The block can accept the next beat in the cycle after
// the result beat is taken. Configuration is to be written over apb only
// while the block is idle; the block itself does not enforce this. All
// registers read back.
module gnss_speed_accel_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    gsaf_in_if.sink                      in_ch,
    gsaf_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsaf_pkg::ADDR_W-1:0]  paddr,
    input  logic [gsaf_pkg::DATA_W-1:0]  pwdata,
    output logic [gsaf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    gsaf_pkg::cfg_t       cfg;
    gsaf_pkg::dp_cmd_t    cmd;
    gsaf_pkg::dp_status_t status;

    // configuration registers
    gsaf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns both handshakes
    gsaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .in_mode   (in_ch.mode),
        .status    (status),
        .cmd       (cmd)
    );

    // filter state and arithmetic; result payload is registered here
    gsaf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .in_has_fix     (in_ch.has_fix),
        .in_speed       (in_ch.speed),
        .in_hdop        (in_ch.hdop),
        .in_time_us     (in_ch.time_us),
        .filtered_speed (out_ch.filtered_speed),
        .speed_valid    (out_ch.speed_valid),
        .accel          (out_ch.accel),
        .accel_valid    (out_ch.accel_valid),
        .moving         (out_ch.moving)
    );

endmodule

// ===== hdl/gsaf_regs.sv =====
// apb configuration register file
module gsaf_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsaf_pkg::ADDR_W-1:0]  paddr,
    input  logic [gsaf_pkg::DATA_W-1:0]  pwdata,
    output logic [gsaf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output gsaf_pkg::cfg_t               cfg
);

    gsaf_pkg::cfg_t   cfg_reg;
    gsaf_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = gsaf_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_deadband     <= gsaf_pkg::RST_DEADBAND;
            cfg_reg.speed_alpha        <= gsaf_pkg::RST_ALPHA;
            cfg_reg.accel_alpha        <= gsaf_pkg::RST_ALPHA;
            cfg_reg.max_hdop           <= gsaf_pkg::RST_MAX_HDOP;
            cfg_reg.max_accel          <= gsaf_pkg::RST_MAX_ACCEL;
            cfg_reg.moving_speed       <= gsaf_pkg::RST_MOVING;
            cfg_reg.movement_memory_ms <= gsaf_pkg::RST_MOVE_MEM;
            cfg_reg.max_hint_age_ms    <= gsaf_pkg::RST_HINT_AGE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                gsaf_pkg::REG_SPEED_DEADBAND:     cfg_reg.speed_deadband     <= pwdata[15:0];
                gsaf_pkg::REG_SPEED_ALPHA:        cfg_reg.speed_alpha        <= pwdata[16:0];
                gsaf_pkg::REG_ACCEL_ALPHA:        cfg_reg.accel_alpha        <= pwdata[16:0];
                gsaf_pkg::REG_MAX_HDOP:           cfg_reg.max_hdop           <= pwdata[15:0];
                gsaf_pkg::REG_MAX_ACCEL:          cfg_reg.max_accel          <= pwdata[14:0];
                gsaf_pkg::REG_MOVING_SPEED:       cfg_reg.moving_speed       <= pwdata[15:0];
                gsaf_pkg::REG_MOVEMENT_MEMORY_MS: cfg_reg.movement_memory_ms <= pwdata;
                gsaf_pkg::REG_MAX_HINT_AGE_MS:    cfg_reg.max_hint_age_ms    <= pwdata;
                default:                          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            gsaf_pkg::REG_SPEED_DEADBAND:     prdata = 32'(cfg_reg.speed_deadband);
            gsaf_pkg::REG_SPEED_ALPHA:        prdata = 32'(cfg_reg.speed_alpha);
            gsaf_pkg::REG_ACCEL_ALPHA:        prdata = 32'(cfg_reg.accel_alpha);
            gsaf_pkg::REG_MAX_HDOP:           prdata = 32'(cfg_reg.max_hdop);
            gsaf_pkg::REG_MAX_ACCEL:          prdata = 32'(cfg_reg.max_accel);
            gsaf_pkg::REG_MOVING_SPEED:       prdata = 32'(cfg_reg.moving_speed);
            gsaf_pkg::REG_MOVEMENT_MEMORY_MS: prdata = cfg_reg.movement_memory_ms;
            gsaf_pkg::REG_MAX_HINT_AGE_MS:    prdata = cfg_reg.max_hint_age_ms;
            default:                          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/gsaf_ctrl.sv =====
// sequencing state machine
module gsaf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 in_mode,
    input  gsaf_pkg::dp_status_t status,
    output gsaf_pkg::dp_cmd_t    cmd
);

    gsaf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gsaf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = gsaf_pkg::OP_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            gsaf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_mode == gsaf_pkg::MODE_QUERY) ? gsaf_pkg::ST_AGE
                                                                   : gsaf_pkg::ST_SMUL;
                end
            end
            gsaf_pkg::ST_SMUL:
            begin
                cmd.op     = gsaf_pkg::OP_SMUL;
                state_next = gsaf_pkg::ST_SUPD;
            end
            gsaf_pkg::ST_SUPD:
            begin
                cmd.op     = gsaf_pkg::OP_SUPD;
                state_next = gsaf_pkg::ST_AGATE;
            end
            gsaf_pkg::ST_AGATE:
            begin
                cmd.op = gsaf_pkg::OP_AGATE;
                if (status.bad_fix)
                    state_next = gsaf_pkg::ST_AGE;
                else if (status.take)
                    state_next = gsaf_pkg::ST_NMUL;
                else
                    state_next = gsaf_pkg::ST_HIST;
            end
            gsaf_pkg::ST_NMUL:
            begin
                cmd.op     = gsaf_pkg::OP_NMUL;
                state_next = gsaf_pkg::ST_DIV;
            end
            gsaf_pkg::ST_DIV:
            begin
                cmd.op = gsaf_pkg::OP_DIV;
                if (status.div_last)
                    state_next = gsaf_pkg::ST_ACHK;
            end
            gsaf_pkg::ST_ACHK:
            begin
                state_next = status.q_ok ? gsaf_pkg::ST_AMUL : gsaf_pkg::ST_HIST;
            end
            gsaf_pkg::ST_AMUL:
            begin
                cmd.op     = gsaf_pkg::OP_AMUL;
                state_next = gsaf_pkg::ST_AUPD;
            end
            gsaf_pkg::ST_AUPD:
            begin
                cmd.op     = gsaf_pkg::OP_AUPD;
                state_next = gsaf_pkg::ST_HIST;
            end
            gsaf_pkg::ST_HIST:
            begin
                cmd.op     = gsaf_pkg::OP_HIST;
                state_next = gsaf_pkg::ST_AGE;
            end
            gsaf_pkg::ST_AGE:
            begin
                cmd.op     = gsaf_pkg::OP_AGE;
                state_next = gsaf_pkg::ST_OUT;
            end
            gsaf_pkg::ST_OUT:
            begin
                cmd.op     = gsaf_pkg::OP_OUT;
                state_next = gsaf_pkg::ST_HOLD;
            end
            gsaf_pkg::ST_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = gsaf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gsaf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gsaf_dp.sv =====
// filter state, shared multiplier, serial divider and result register
module gsaf_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gsaf_pkg::cfg_t                    cfg,
    input  gsaf_pkg::dp_cmd_t                 cmd,
    output gsaf_pkg::dp_status_t              status,
    input  logic                              in_has_fix,
    input  logic [gsaf_pkg::SPEED_W-1:0]      in_speed,
    input  logic [gsaf_pkg::HDOP_W-1:0]       in_hdop,
    input  logic [63:0]                       in_time_us,
    output logic [gsaf_pkg::SPEED_W-1:0]      filtered_speed,
    output logic                              speed_valid,
    output logic signed [gsaf_pkg::ACCEL_W-1:0] accel,
    output logic                              accel_valid,
    output logic                              moving
);

    localparam int SW = gsaf_pkg::SPEED_W;
    localparam int TW = gsaf_pkg::TIME_W;
    localparam int MW = gsaf_pkg::MUL_W;
    localparam int PW = gsaf_pkg::PROD_W;
    localparam int NW = gsaf_pkg::NUM_W;
    localparam int DW = gsaf_pkg::DT_W;
    localparam int LW = gsaf_pkg::LIM_W;
    localparam int CW = gsaf_pkg::CMP_W;

    // latched beat
    logic                           fix_reg;
    logic [SW-1:0]                  speed_reg;
    logic [gsaf_pkg::HDOP_W-1:0]    hdop_reg;
    logic [TW-1:0]                  t_reg;

    // filter state
    logic [SW-1:0]                  smoothed_reg, fspeed_reg, prev_speed_reg;
    logic                           sfv_reg, last_fix_reg, ever_fix_reg, prev_valid_reg, afv_reg;
    logic [gsaf_pkg::HDOP_W-1:0]    last_hdop_reg;
    logic [TW-1:0]                  last_fix_time_reg, prev_time_reg;
    logic [SW-1:0]                  faccel_reg;

    // working registers
    logic signed [PW-1:0]           prod_reg;
    logic [SW-1:0]                  mag_reg, q_raw_reg;
    logic                           neg_reg;
    logic [DW-1:0]                  dt_reg, rem_reg;
    logic [NW-1:0]                  num_reg;
    logic [gsaf_pkg::CNT_W-1:0]     cnt_reg;
    logic                           lt_reg;
    logic [TW-1:0]                  age_reg;
    logic [LW-1:0]                  hint_lim_reg, mov_lim_reg;

    // result register
    logic [SW-1:0]                  o_speed_reg;
    logic                           o_sv_reg, o_av_reg, o_mv_reg;
    logic [SW-1:0]                  o_accel_reg;

    logic [SW-1:0]                  db, sm_new;
    logic signed [MW-1:0]           mul_a, mul_b, raw_s;
    logic signed [PW-1:0]           mul_p, inc;
    logic [TW-1:0]                  dt_full;
    logic                           dt_win;
    logic [DW:0]                    rem_sh;
    logic                           rem_ge;
    logic                           sv, hint_ok, mov_ok;

    assign db = (speed_reg < cfg.speed_deadband) ? '0 : speed_reg;

    // signed raw derivative from magnitude and sign
    assign raw_s = neg_reg ? -$signed({2'b00, q_raw_reg}) : $signed({2'b00, q_raw_reg});

    // one multiplier shared by both ema updates
    always_comb
    begin
        if (cmd.op == gsaf_pkg::OP_AMUL)
        begin
            mul_a = raw_s - $signed({{2{faccel_reg[SW-1]}}, faccel_reg});
            mul_b = $signed({1'b0, gsaf_pkg::sat_alpha(cfg.accel_alpha)});
        end
        else
        begin
            mul_a = $signed({2'b00, db}) - $signed({2'b00, smoothed_reg});
            mul_b = $signed({1'b0, gsaf_pkg::sat_alpha(cfg.speed_alpha)});
        end
    end
    assign mul_p = mul_a * mul_b;

    // rounded ema increment
    assign inc = (prod_reg + $signed(gsaf_pkg::ROUND_HALF)) >>> gsaf_pkg::EMA_SHIFT;

    always_comb
    begin
        if (db == '0)
            sm_new = '0;
        else if (!sfv_reg)
            sm_new = db;
        else
            sm_new = smoothed_reg + inc[SW-1:0];
    end

    assign dt_full = t_reg - prev_time_reg;
    assign dt_win  = (dt_full >= TW'(gsaf_pkg::DT_MIN)) && (dt_full <= TW'(gsaf_pkg::DT_MAX));

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign rem_ge = rem_sh >= {1'b0, dt_reg};

    assign status.bad_fix  = !fix_reg || (hdop_reg > cfg.max_hdop);
    assign status.take     = prev_valid_reg && (t_reg > prev_time_reg) && dt_win;
    assign status.div_last = cnt_reg == gsaf_pkg::CNT_W'(NW - 1);
    assign status.q_ok     = num_reg <= NW'(cfg.max_accel);

    assign hint_ok = !lt_reg && (CW'(age_reg) <= CW'(hint_lim_reg));
    assign mov_ok  = !lt_reg && (CW'(age_reg) <= CW'(mov_lim_reg));
    assign sv      = last_fix_reg && (last_hdop_reg <= cfg.max_hdop) && hint_ok;

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fix_reg   <= in_has_fix;
            speed_reg <= in_speed;
            hdop_reg  <= in_hdop;
            t_reg     <= in_time_us[TW-1:0];
        end
        case (cmd.op)
            gsaf_pkg::OP_SMUL,
            gsaf_pkg::OP_AMUL:
            begin
                prod_reg <= mul_p;
            end
            gsaf_pkg::OP_AGATE:
            begin
                neg_reg <= fspeed_reg < prev_speed_reg;
                mag_reg <= (fspeed_reg < prev_speed_reg) ? prev_speed_reg - fspeed_reg
                                                        : fspeed_reg - prev_speed_reg;
                dt_reg  <= dt_full[DW-1:0];
            end
            gsaf_pkg::OP_NMUL:
            begin
                num_reg <= NW'(mag_reg) * NW'(gsaf_pkg::US_PER_S) + NW'(dt_reg >> 1);
                rem_reg <= '0;
            end
            gsaf_pkg::OP_DIV:
            begin
                rem_reg   <= rem_ge ? DW'(rem_sh - {1'b0, dt_reg}) : rem_sh[DW-1:0];
                num_reg   <= {num_reg[NW-2:0], rem_ge};
                q_raw_reg <= {num_reg[SW-2:0], rem_ge};
            end
            gsaf_pkg::OP_AGE:
            begin
                lt_reg       <= t_reg < last_fix_time_reg;
                age_reg      <= t_reg - last_fix_time_reg;
                hint_lim_reg <= LW'(cfg.max_hint_age_ms) * LW'(gsaf_pkg::US_PER_MS)
                              + LW'(gsaf_pkg::US_PER_MS - 10'd1);
                mov_lim_reg  <= LW'(cfg.movement_memory_ms) * LW'(gsaf_pkg::US_PER_MS)
                              + LW'(gsaf_pkg::US_PER_MS - 10'd1);
            end
            gsaf_pkg::OP_OUT:
            begin
                o_speed_reg <= sv ? fspeed_reg : '0;
                o_sv_reg    <= sv;
                o_av_reg    <= afv_reg && sv;
                o_accel_reg <= (afv_reg && sv) ? faccel_reg : '0;
                o_mv_reg    <= ever_fix_reg && mov_ok && (fspeed_reg >= cfg.moving_speed);
            end
            default: ;
        endcase
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg      <= '0;
            fspeed_reg        <= '0;
            sfv_reg           <= 1'b0;
            last_fix_time_reg <= '0;
            last_fix_reg      <= 1'b0;
            last_hdop_reg     <= '0;
            ever_fix_reg      <= 1'b0;
            prev_valid_reg    <= 1'b0;
            prev_speed_reg    <= '0;
            prev_time_reg     <= '0;
            afv_reg           <= 1'b0;
            faccel_reg        <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            case (cmd.op)
                gsaf_pkg::OP_SUPD:
                begin
                    if (fix_reg)
                    begin
                        smoothed_reg      <= sm_new;
                        sfv_reg           <= 1'b1;
                        fspeed_reg        <= (sm_new < cfg.speed_deadband) ? '0 : sm_new;
                        last_fix_time_reg <= t_reg;
                        ever_fix_reg      <= 1'b1;
                    end
                    else if (last_fix_reg)
                    begin
                        sfv_reg <= 1'b0;
                    end
                    last_fix_reg  <= fix_reg;
                    last_hdop_reg <= hdop_reg;
                end
                gsaf_pkg::OP_AGATE:
                begin
                    if (status.bad_fix)
                    begin
                        prev_valid_reg <= 1'b0;
                        afv_reg        <= 1'b0;
                    end
                end
                gsaf_pkg::OP_NMUL:
                begin
                    cnt_reg <= '0;
                end
                gsaf_pkg::OP_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                gsaf_pkg::OP_AUPD:
                begin
                    faccel_reg <= afv_reg ? faccel_reg + inc[SW-1:0] : raw_s[SW-1:0];
                    afv_reg    <= 1'b1;
                end
                gsaf_pkg::OP_HIST:
                begin
                    prev_speed_reg <= fspeed_reg;
                    prev_time_reg  <= t_reg;
                    prev_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign filtered_speed = o_speed_reg;
    assign speed_valid    = o_sv_reg;
    assign accel          = $signed(o_accel_reg);
    assign accel_valid    = o_av_reg;
    assign moving         = o_mv_reg;

endmodule

// ===== hdl/gsaf_checker.sv =====
// port-level checks and their binding to the top level
module gsaf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [gsaf_pkg::SPEED_W-1:0]  filtered_speed,
    input logic                          speed_valid,
    input logic [gsaf_pkg::ACCEL_W-1:0]  accel,
    input logic                          accel_valid
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_speed) && $stable(accel))
        else $error("result beat changed while stalled");

    // one beat in flight: no acceptance while a result waits
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("beat accepted while result pending");

    // invalid hints read as zero, accel validity needs speed validity
    a_zero_hint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_valid || (filtered_speed == '0 && !accel_valid && accel == '0)))
        else $error("invalid hint not zeroed");

    // a result never shows the cycle after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared too early");

endmodule

bind gnss_speed_accel_filter gsaf_checker u_gsaf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .filtered_speed (out_ch.filtered_speed),
    .speed_valid    (out_ch.speed_valid),
    .accel          (out_ch.accel),
    .accel_valid    (out_ch.accel_valid)
);

// ===== tb/gnss_speed_accel_filter_tb.sv =====
// self-checking testbench for the gnss speed and acceleration filter
`timescale 1ns / 100ps

module gnss_speed_accel_filter_tb;

    // result beat as predicted
    typedef struct packed {
        logic [15:0]        filtered_speed;
        logic               speed_valid;
        logic signed [15:0] accel;
        logic               accel_valid;
        logic               moving;
    } hint_t;

    // input beat
    typedef struct packed {
        logic        mode;
        logic        has_fix;
        logic [15:0] speed;
        logic [15:0] hdop;
        logic [63:0] time_us;
    } fix_t;

    // one row of the directed table; check_exp set where the answer is typed in
    typedef struct {
        fix_t  beat;
        logic  check_exp;
        hint_t exp_hint;
    } row_t;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_LEN    = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [gsaf_pkg::ADDR_W-1:0] paddr = '0;
    logic [gsaf_pkg::DATA_W-1:0] pwdata = '0;
    logic [gsaf_pkg::DATA_W-1:0] prdata;
    logic pready;

    gsaf_in_if  in_ch ();
    gsaf_out_if out_ch ();

    gnss_speed_accel_filter dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor: own copy of the configuration and filter state
    // ---------------------------------------------------------------
    logic [15:0] m_deadband, m_max_hdop, m_moving_speed;
    logic [16:0] m_speed_alpha, m_accel_alpha;
    logic [14:0] m_max_accel;
    logic [31:0] m_move_mem, m_hint_age;

    logic [15:0] m_smoothed, m_filt_speed, m_last_hdop, m_prev_speed;
    logic        m_sfilt_ok, m_last_fix, m_ever_fix, m_prev_ok, m_afilt_ok;
    logic [63:0] m_last_fix_time, m_prev_time;
    logic signed [15:0] m_filt_accel;

    function automatic logic [15:0] ema_mix(input logic [15:0] old_v,
                                            input logic [15:0] new_v,
                                            input logic [16:0] alpha);
        logic [16:0] w;
        logic [63:0] acc;
        w   = (alpha > 17'd65536) ? 17'd65536 : alpha;
        acc = 64'(old_v) * (64'd65536 - 64'(w)) + 64'(new_v) * 64'(w) + 64'd32768;
        return acc[31:16];
    endfunction

    function automatic logic fresh_fix(input logic [63:0] now, input logic [31:0] lim_ms);
        if (now < m_last_fix_time)
            return 1'b0;
        return ((now - m_last_fix_time) / 64'd1000) <= 64'(lim_ms);
    endfunction

    task automatic predict_reset();
        m_deadband = gsaf_pkg::RST_DEADBAND;
        m_speed_alpha = gsaf_pkg::RST_ALPHA;
        m_accel_alpha = gsaf_pkg::RST_ALPHA;
        m_max_hdop = gsaf_pkg::RST_MAX_HDOP;
        m_max_accel = gsaf_pkg::RST_MAX_ACCEL;
        m_moving_speed = gsaf_pkg::RST_MOVING;
        m_move_mem = gsaf_pkg::RST_MOVE_MEM;
        m_hint_age = gsaf_pkg::RST_HINT_AGE;
        m_smoothed = '0; m_filt_speed = '0; m_last_hdop = '0; m_prev_speed = '0;
        m_sfilt_ok = 0; m_last_fix = 0; m_ever_fix = 0; m_prev_ok = 0; m_afilt_ok = 0;
        m_last_fix_time = '0; m_prev_time = '0; m_filt_accel = '0;
    endtask

    task automatic predict_config(input gsaf_pkg::reg_idx_t idx, input logic [31:0] v);
        case (idx)
            gsaf_pkg::REG_SPEED_DEADBAND:     m_deadband     = v[15:0];
            gsaf_pkg::REG_SPEED_ALPHA:        m_speed_alpha  = v[16:0];
            gsaf_pkg::REG_ACCEL_ALPHA:        m_accel_alpha  = v[16:0];
            gsaf_pkg::REG_MAX_HDOP:           m_max_hdop     = v[15:0];
            gsaf_pkg::REG_MAX_ACCEL:          m_max_accel    = v[14:0];
            gsaf_pkg::REG_MOVING_SPEED:       m_moving_speed = v[15:0];
            gsaf_pkg::REG_MOVEMENT_MEMORY_MS: m_move_mem     = v;
            gsaf_pkg::REG_MAX_HINT_AGE_MS:    m_hint_age     = v;
            default: ;
        endcase
    endtask

    // acceleration path of a reading
    function automatic void predict_accel(input logic fix, input logic [15:0] hdop,
                                          input logic [63:0] t);
        logic [63:0] dt, mag, q;
        logic neg;
        logic signed [15:0] raw;
        if (!fix || hdop > m_max_hdop)
        begin
            m_prev_ok = 0;
            m_afilt_ok = 0;
            return;
        end
        if (m_prev_ok && t > m_prev_time)
        begin
            dt = t - m_prev_time;
            if (dt >= 64'd20000 && dt <= 64'd2000000)
            begin
                neg = m_filt_speed < m_prev_speed;
                mag = neg ? 64'(m_prev_speed - m_filt_speed) : 64'(m_filt_speed - m_prev_speed);
                q   = (mag * 64'd1000000 + dt / 2) / dt;
                if (q <= 64'(m_max_accel))
                begin
                    raw = neg ? -16'(q) : 16'(q);
                    if (!m_afilt_ok)
                    begin
                        m_filt_accel = raw;
                        m_afilt_ok = 1;
                    end
                    else
                        m_filt_accel = ema_mix(m_filt_accel ^ 16'h8000, raw ^ 16'h8000,
                                               m_accel_alpha) ^ 16'h8000;
                end
            end
        end
        m_prev_speed = m_filt_speed;
        m_prev_time = t;
        m_prev_ok = 1;
    endfunction

    function automatic hint_t predict_hint(input fix_t b);
        hint_t h;
        logic [15:0] dbs;
        logic sv, mv;
        if (b.mode == gsaf_pkg::MODE_READING)
        begin
            if (b.has_fix)
            begin
                dbs = (b.speed < m_deadband) ? 16'd0 : b.speed;
                if (dbs == 0)
                begin
                    m_smoothed = '0;
                    m_sfilt_ok = 1;
                end
                else if (!m_sfilt_ok)
                begin
                    m_smoothed = dbs;
                    m_sfilt_ok = 1;
                end
                else
                    m_smoothed = ema_mix(m_smoothed, dbs, m_speed_alpha);
                m_filt_speed = (m_smoothed < m_deadband) ? 16'd0 : m_smoothed;
                m_last_fix_time = b.time_us;
                m_ever_fix = 1;
            end
            else if (m_last_fix)
                m_sfilt_ok = 0;
            predict_accel(b.has_fix, b.hdop, b.time_us);
            m_last_fix = b.has_fix;
            m_last_hdop = b.hdop;
        end
        sv = m_last_fix && m_last_hdop <= m_max_hdop && fresh_fix(b.time_us, m_hint_age);
        mv = m_ever_fix && fresh_fix(b.time_us, m_move_mem) && m_filt_speed >= m_moving_speed;
        h.filtered_speed = sv ? m_filt_speed : '0;
        h.speed_valid    = sv;
        h.accel_valid    = sv && m_afilt_ok;
        h.accel          = h.accel_valid ? m_filt_accel : '0;
        h.moving         = mv;
        return h;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard
    // ---------------------------------------------------------------
    hint_t pending_hints[$];
    hint_t typed_hints[$];
    logic  typed_flags[$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    cycles = 0;
    int    sent_items = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;     // asks for one long receiver hold-off
    logic hold_on = 1'b0;

    task automatic report(input string what, input hint_t e, input hint_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: exp spd=%0d sv=%0b acc=%0d av=%0b mv=%0b | got spd=%0d sv=%0b acc=%0d av=%0b mv=%0b",
                     what, e.filtered_speed, e.speed_valid, e.accel, e.accel_valid, e.moving,
                     a.filtered_speed, a.speed_valid, a.accel, a.accel_valid, a.moving);
    endtask

    // long hold-off, counted in its own process
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_on <= 1'b0;
    end

    // receiver: ready driven at the edge, results sampled at the same edge
    always @(posedge clk)
    begin
        hint_t got, e, typed;
        logic  has_typed;
        cycles <= cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.filtered_speed = out_ch.filtered_speed;
            got.speed_valid    = out_ch.speed_valid;
            got.accel          = out_ch.accel;
            got.accel_valid    = out_ch.accel_valid;
            got.moving         = out_ch.moving;
            results_seen <= results_seen + 1;
            if (pending_hints.size() == 0)
                report("unexpected beat", '0, got);
            else
            begin
                e = pending_hints.pop_front();
                typed = typed_hints.pop_front();
                has_typed = typed_flags.pop_front();
                if (got.filtered_speed !== e.filtered_speed) report("filtered_speed", e, got);
                else if (got.speed_valid !== e.speed_valid)  report("speed_valid", e, got);
                else if (got.accel !== e.accel)              report("accel", e, got);
                else if (got.accel_valid !== e.accel_valid)  report("accel_valid", e, got);
                else if (got.moving !== e.moving)            report("moving", e, got);
                else if (has_typed && got !== typed)         report("table entry", typed, got);
            end
        end
        // long hold-off takes precedence over random stalls
        if (hold_on)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // cycle limit
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    task automatic apb_write(input gsaf_pkg::reg_idx_t idx, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= gsaf_pkg::ADDR_W'(4 * int'(idx)); pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        predict_config(idx, v);
        @(posedge clk);
    endtask

    // send one beat; expectation queued at acceptance, valid left high
    task automatic send_beat(input fix_t b, input logic typed_ok, input hint_t typed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= b.mode; in_ch.has_fix <= b.has_fix; in_ch.speed <= b.speed;
        in_ch.hdop <= b.hdop; in_ch.time_us <= b.time_us;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_hints.push_back(predict_hint(b));
        typed_hints.push_back(typed);
        typed_flags.push_back(typed_ok);
        sent_items++;
    endtask

    // drop valid, wait for all results, then drain the block's longest path
    task automatic wait_idle();
        in_ch.valid <= 0;
        while (pending_hints.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // random beat: mostly a trackable stream of fixes, some noise
    logic [63:0] stream_t = 64'd1000000;
    logic [15:0] stream_v = 16'd1000;

    function automatic fix_t random_beat();
        fix_t b;
        int k;
        k = $urandom_range(99);
        b.mode = gsaf_pkg::MODE_READING;
        b.has_fix = 1;
        b.hdop = 16'($urandom_range(400));
        if (k < 70)
        begin
            // spacing mostly inside the dt window, speed walks so derivatives stay plausible
            stream_t = stream_t + 64'($urandom_range(2100000, 15000));
            stream_v = stream_v + 16'($urandom_range(600)) - 16'd300;
            b.speed = stream_v;
            b.time_us = stream_t;
        end
        else if (k < 82)
        begin
            b.mode = gsaf_pkg::MODE_QUERY;
            b.has_fix = 1'($urandom_range(1));
            b.speed = 16'($urandom);
            b.hdop = 16'($urandom);
            b.time_us = stream_t + 64'($urandom_range(7000000)) - 64'd500000;
        end
        else if (k < 88)
        begin
            b.has_fix = 0;
            b.speed = 16'($urandom);
            stream_t = stream_t + 64'($urandom_range(500000));
            b.time_us = stream_t;
        end
        else if (k < 94)
        begin
            b.speed = 16'($urandom);
            b.hdop = 16'($urandom);
            b.time_us = stream_t - 64'($urandom_range(100000));
        end
        else
        begin
            b.speed = 16'($urandom);
            b.time_us = {$urandom, $urandom};
            b.mode = 1'($urandom_range(1));
        end
        return b;
    endfunction

    // directed table
    function automatic row_t mk(input logic md, input logic fx, input logic [15:0] sp,
                                input logic [15:0] hd, input logic [63:0] t,
                                input logic chk, input hint_t e);
        row_t r;
        r.beat = '{md, fx, sp, hd, t};
        r.check_exp = chk;
        r.exp_hint = e;
        return r;
    endfunction

    row_t dir_rows[$];
    int   ph;

    initial
    begin
        hint_t none;
        none = '0;
        in_ch.valid = 0; in_ch.mode = 0; in_ch.has_fix = 0; in_ch.speed = 0;
        in_ch.hdop = 0; in_ch.time_us = 0; out_ch.ready = 0;
        predict_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // after reset: query sees nothing
        dir_rows.push_back(mk(gsaf_pkg::MODE_QUERY, 1, 16'hFFFF, 16'hFFFF, 64'd0, 1, none));
        // first fix below deadband: standstill, zero speed valid
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd0, 16'd0, 64'd100000, 1,
                              '{16'd0, 1'b1, 16'sd0, 1'b0, 1'b0}));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd1280, 16'd100, 64'd200000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd1536, 16'd100, 64'd300000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd1792, 16'd300, 64'd400000, 0, none));
        // spacing at window edges
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd2048, 16'd0, 64'd420000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd2048, 16'd0, 64'd2420000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd2100, 16'd0, 64'd2439999, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd2100, 16'd0, 64'd4440000, 0, none));
        // non-increasing timestamp, implausible jump
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd2200, 16'd0, 64'd4440000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'hFFFF, 16'd0, 64'd4500000, 0, none));
        // high hdop invalidates, query in the future and past
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd3000, 16'hFFFF, 64'd4600000, 0,
                              none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd3000, 16'd50, 64'd4700000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_QUERY, 0, 16'd0, 16'd0, 64'd4600000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_QUERY, 0, 16'd0, 16'd0, 64'd6700999, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_QUERY, 0, 16'd0, 16'd0, 64'd6701000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_QUERY, 0, 16'd0, 16'd0, 64'd9701000, 0, none));
        // fix lost, then regained
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 0, 16'hFFFF, 16'hFFFF, 64'd4800000, 0,
                              none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd4000, 16'd10, 64'd4900000, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_READING, 1, 16'd100, 16'd10,
                              64'hFFFF_FFFF_FFFF_FFFF, 0, none));
        dir_rows.push_back(mk(gsaf_pkg::MODE_QUERY, 1, 16'd0, 16'd0,
                              64'hFFFF_FFFF_FFFF_FFFF, 0, none));

        recv_stall_pct = 0; send_idle_pct = 0;
        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].check_exp, dir_rows[i].exp_hint);
        wait_idle();

        // random phases with different settings and idling
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 87; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 87;
                end
                3:
                begin
                    send_idle_pct = 26; recv_stall_pct = 26;
                end
                default:
                begin
                    send_idle_pct = $urandom_range(30);
                    recv_stall_pct = $urandom_range(30);
                end
            endcase
            // extremes on some phases, random values on others
            case (ph)
                1:
                begin
                    apb_write(gsaf_pkg::REG_SPEED_DEADBAND, 0);
                    apb_write(gsaf_pkg::REG_SPEED_ALPHA, 17'h1FFFF);
                    apb_write(gsaf_pkg::REG_ACCEL_ALPHA, 0);
                    apb_write(gsaf_pkg::REG_MAX_HDOP, 16'hFFFF);
                    apb_write(gsaf_pkg::REG_MAX_ACCEL, 15'h7FFF);
                    apb_write(gsaf_pkg::REG_MOVING_SPEED, 0);
                    apb_write(gsaf_pkg::REG_MOVEMENT_MEMORY_MS, 0);
                    apb_write(gsaf_pkg::REG_MAX_HINT_AGE_MS, 32'hFFFF_FFFF);
                end
                2:
                begin
                    apb_write(gsaf_pkg::REG_SPEED_DEADBAND, 16'hFFFF);
                    apb_write(gsaf_pkg::REG_SPEED_ALPHA, 0);
                    apb_write(gsaf_pkg::REG_ACCEL_ALPHA, 17'd65536);
                    apb_write(gsaf_pkg::REG_MAX_HDOP, 0);
                    apb_write(gsaf_pkg::REG_MAX_ACCEL, 0);
                    apb_write(gsaf_pkg::REG_MOVING_SPEED, 16'hFFFF);
                    apb_write(gsaf_pkg::REG_MOVEMENT_MEMORY_MS, 32'hFFFF_FFFF);
                    apb_write(gsaf_pkg::REG_MAX_HINT_AGE_MS, 0);
                end
                0: ;
                default:
                begin
                    apb_write(gsaf_pkg::REG_SPEED_DEADBAND, $urandom_range(400));
                    apb_write(gsaf_pkg::REG_SPEED_ALPHA, $urandom_range(70000));
                    apb_write(gsaf_pkg::REG_ACCEL_ALPHA, $urandom_range(70000));
                    apb_write(gsaf_pkg::REG_MAX_HDOP, $urandom_range(600));
                    apb_write(gsaf_pkg::REG_MAX_ACCEL, $urandom_range(32767));
                    apb_write(gsaf_pkg::REG_MOVING_SPEED, $urandom_range(2000));
                    apb_write(gsaf_pkg::REG_MOVEMENT_MEMORY_MS, $urandom_range(8000));
                    apb_write(gsaf_pkg::REG_MAX_HINT_AGE_MS, $urandom_range(4000));
                end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (ph == 0)
                hold_req = 1'b1;
            repeat (200)
                send_beat(random_beat(), 0, none);
            wait_idle();
        end

        $display("covered %0d beats, %0d results, 7 register settings incl. extremes",
                 sent_items, results_seen);
        if (mismatches == 0 && pending_hints.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/gsaf_pkg.sv
hdl/gsaf_if.sv
hdl/gsaf_regs.sv
hdl/gsaf_ctrl.sv
hdl/gsaf_dp.sv
hdl/gnss_speed_accel_filter.sv
hdl/gsaf_checker.sv
tb/gnss_speed_accel_filter_tb.sv
